// ===== sv/tkrm_pkg.sv =====
// Shared constants, state encoding and table control types for the top-K tracker.
package tkrm_pkg;

    localparam int SLOTS      = 10;
    localparam int COUNT_BITS = 16;

    localparam int ID_W  = 32;
    localparam int CNT_W = 16;
    localparam int SEL_W = 4;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEEP_W = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;

    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_READ,
        S_RDATA,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [ID_W-1:0]   wr_id;
        logic [KEEP_W-1:0] wr_cnt;
    } t_tbl_req;

endpackage

// ===== sv/tkrm_table.sv =====
// Slot table: one write port, one registered read port, per-slot valid bits.
module tkrm_table
    import tkrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_req          i_req,
    output logic [ID_W-1:0]   o_rd_id,
    output logic [KEEP_W-1:0] o_rd_cnt
);

    logic [ID_W-1:0]   mem_id  [SLOTS];
    logic [KEEP_W-1:0] mem_cnt [SLOTS];
    logic [SLOTS-1:0]  r_valid;

    logic [ID_W-1:0]   r_rd_id;
    logic [KEEP_W-1:0] r_rd_cnt;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem_id[i_req.wr_addr]  <= i_req.wr_id;
            mem_cnt[i_req.wr_addr] <= i_req.wr_cnt;
        end
        if (i_req.rd_en) begin
            r_rd_id  <= mem_id[i_req.rd_addr];
            r_rd_cnt <= mem_cnt[i_req.rd_addr];
            r_rd_vld <= r_valid[i_req.rd_addr];
        end
    end

    // A slot never written since reset reads as zero.
    assign o_rd_id  = r_rd_vld ? r_rd_id  : '0;
    assign o_rd_cnt = r_rd_vld ? r_rd_cnt : '0;

endmodule

// ===== sv/top_k_replace_min_tracker_core.sv =====
// Offer: after acceptance the sequencer scans every slot, then passes S_LAST and S_DECIDE on to S_OUT.
// The offer time is set by the minimum scan, which reads one slot per cycle through the
// single read port of the slot table and one shared comparator.
// Read: the sequencer passes S_READ and S_RDATA on to S_OUT; a new offer or read is taken only in idle.
// A synchronous active-low reset returns the sequencer to idle, drops the output valid
// and marks every slot empty, so all slots read as id 0 and count 0.
module top_k_replace_min_tracker_core
    import tkrm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_kind,
    input  logic [ID_W-1:0]  i_key_id,
    input  logic [CNT_W-1:0] i_link_count,
    input  logic [SEL_W-1:0] i_slot_select,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_accepted,
    output logic [SEL_W-1:0] o_slot_number,
    output logic [ID_W-1:0]  o_slot_id,
    output logic [CNT_W-1:0] o_slot_count
);

    t_state r_state, n_state;

    logic [IDX_W-1:0]  r_idx;
    logic              r_dv;
    logic [IDX_W-1:0]  r_didx;

    logic [ID_W-1:0]   r_key_id;
    logic [KEEP_W-1:0] r_cnt;
    logic [SEL_W-1:0]  r_sel;

    logic [KEEP_W-1:0] r_low;
    logic [IDX_W-1:0]  r_best;
    logic [ID_W-1:0]   r_best_id;

    logic              r_res_acc;
    logic [SEL_W-1:0]  r_res_slot;
    logic [ID_W-1:0]   r_res_id;
    logic [KEEP_W-1:0] r_res_cnt;

    logic              r_out_valid;
    logic              r_out_acc;
    logic [SEL_W-1:0]  r_out_slot;
    logic [ID_W-1:0]   r_out_id;
    logic [KEEP_W-1:0] r_out_cnt;

    t_tbl_req          tbl_req;
    logic [ID_W-1:0]   tbl_id;
    logic [KEEP_W-1:0] tbl_cnt;

    logic [KEEP_W-1:0] cmp_a;
    logic              cmp_le;
    logic              in_take;
    logic              load_out;
    logic              scan_take;
    logic              sel_ok;

    tkrm_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (tbl_req),
        .o_rd_id  (tbl_id),
        .o_rd_cnt (tbl_cnt)
    );

    // The comparator is shared: it tracks the minimum during the scan and
    // decides the replacement afterwards.
    assign cmp_a  = (r_state == S_DECIDE) ? r_cnt : tbl_cnt;
    assign cmp_le = (cmp_a <= r_low);

    // A later slot with an equal count wins, so ties go to the highest slot.
    assign scan_take = r_dv && ((r_didx == '0) || cmp_le);
    assign sel_ok    = (int'(r_sel) < SLOTS);

    assign in_take  = i_valid && !o_stall;
    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_kind == KIND_READ) ? S_READ : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == IDX_W'(SLOTS - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_READ:   n_state = S_RDATA;
            S_RDATA:  n_state = S_OUT;
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        tbl_req         = '0;
        tbl_req.wr_addr = r_best;
        tbl_req.wr_id   = r_key_id;
        tbl_req.wr_cnt  = r_cnt;
        o_stall         = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_SCAN: begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = r_idx;
            end
            S_DECIDE: begin
                tbl_req.wr_en = !cmp_le;
            end
            S_READ: begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = IDX_W'(r_sel);
            end
            S_LAST, S_RDATA, S_OUT: begin
                o_stall = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_take) begin
                r_idx <= '0;
                r_dv  <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_dv <= 1'b1;
                if (r_idx != IDX_W'(SLOTS - 1)) begin
                    r_idx <= r_idx + 1'b1;
                end
            end else begin
                r_dv <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_key_id <= i_key_id;
            r_cnt    <= i_link_count[KEEP_W-1:0];
            r_sel    <= i_slot_select;
        end
        if (r_state == S_SCAN) begin
            r_didx <= r_idx;
        end
        if (scan_take) begin
            r_low     <= tbl_cnt;
            r_best    <= r_didx;
            r_best_id <= tbl_id;
        end
        if (r_state == S_DECIDE) begin
            r_res_acc  <= !cmp_le;
            r_res_slot <= SEL_W'(r_best);
            r_res_id   <= cmp_le ? r_best_id : r_key_id;
            r_res_cnt  <= cmp_le ? r_low : r_cnt;
        end else if (r_state == S_RDATA) begin
            r_res_acc  <= 1'b0;
            r_res_slot <= r_sel;
            r_res_id   <= sel_ok ? tbl_id  : '0;
            r_res_cnt  <= sel_ok ? tbl_cnt : '0;
        end
        if (load_out) begin
            r_out_acc  <= r_res_acc;
            r_out_slot <= r_res_slot;
            r_out_id   <= r_res_id;
            r_out_cnt  <= r_res_cnt;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_accepted    = r_out_acc;
    assign o_slot_number = r_out_slot;
    assign o_slot_id     = r_out_id;
    assign o_slot_count  = CNT_W'(r_out_cnt);

endmodule

// ===== sv/tkrm_checker.sv =====
// Port-level checker for the top-K tracker and its bind to the top level.
module tkrm_checker
    import tkrm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic             o_accepted,
    input logic [CNT_W-1:0] o_slot_count
);

    // A result waiting on a stalled receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    // The block works on one transaction at a time.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a transaction is in progress");

    // A replacement only happens for a count above the minimum, so it is never zero.
    a_acc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_slot_count != '0))
        else $error("accepted offer reports a zero count");

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

bind top_k_replace_min_tracker_core tkrm_checker u_tkrm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_accepted   (o_accepted),
    .o_slot_count (o_slot_count)
);
